// ----- sv/gpr_pkg.sv -----
// Shared types and constants for the Gaussian pyramid reduce block.
// Used by gpr_front, gpr_fifo, gpr_back and the top level.
package gpr_pkg;

	localparam int COL_BITS   = 12;
	localparam int FIFO_DEPTH = 4;
	localparam int IDX_BITS   = 8;
	localparam int CFG_BITS   = 11;

	localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 8'd0;
	localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 8'd1;

	// binomial taps 1,4,6,4,1
	localparam logic [2:0] TAP_WEIGHT [5] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

	typedef struct packed {
		logic [23:0]         pix;       // {blue, green, red}
		logic [COL_BITS-1:0] col;       // line store column
		logic                emit;      // centre is on an even row and column
		logic [4:0]          row_mask;  // rows of the window inside the frame
		logic [4:0]          col_mask;  // columns of the window inside the frame
		logic                frame_end;
	} item_t;

endpackage

// ----- sv/gaussian_pyramid_reduce.sv -----
// Gaussian pyramid reduce: RGB pixels in raster order are blurred by the 5x5
// binomial kernel (1,4,6,4,1)x(1,4,6,4,1)/256, taps outside the frame dropped,
// rounded once and saturated, and only even rows and columns are sent out.
// One item per clock sustained while m_axis_tready does not stall the back end
// after the queue. The window centre lags the input by 2*width+2 items, so
// each frame must be followed by 2*width+2 items with tuser (flush) set.
// Writing either frame register restarts the frame. Line store: one RAM of
// MAX_WIDTH words holding four lines, read and written once per item.
module gaussian_pyramid_reduce #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [gpr_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [gpr_pkg::CFG_BITS-1:0] cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [23:0]                  s_axis_tdata,  // red, green, blue
	input  logic                         s_axis_tuser,  // flush
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [23:0]                  m_axis_tdata,  // red_out, green_out, blue_out
	output logic                         m_axis_tlast   // frame_end
);

	logic           push, pop, q_full, q_valid;
	gpr_pkg::item_t f_item, q_item;

	assign cfg_ready = 1'b1;

	gpr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_pix    ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
		.in_flush  (s_axis_tuser),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.item      (f_item)
	);

	gpr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (f_item),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.rd_item   (q_item)
	);

	gpr_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ----- sv/gpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gpr_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/gpr_front.sv -----
// Front end: frame registers, input and window-centre position tracking,
// tap masks. Depends on gpr_pkg.
module gpr_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gpr_pkg::IDX_BITS-1:0]    cfg_index,
	input  logic [gpr_pkg::CFG_BITS-1:0]    cfg_data,
	input  logic                            in_valid,
	input  logic [23:0]                     in_pix,
	input  logic                            in_flush,
	input  logic                            q_full,
	output logic                            in_ready,
	output logic                            push,
	output gpr_pkg::item_t                  item
);

	localparam int DWW = $clog2(MAX_WIDTH + 1);
	localparam int DWH = $clog2(MAX_HEIGHT + 1);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int HW  = $clog2(MAX_HEIGHT);
	localparam int RW  = $clog2(MAX_HEIGHT + 4);
	localparam int LW  = $clog2(2 * MAX_WIDTH + 3);
	localparam int W_RST = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
	localparam int H_RST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

	logic [DWW-1:0] width_q;
	logic [DWH-1:0] height_q;
	logic [CW-1:0]  col_q, ccol_q;
	logic [RW-1:0]  row_q;
	logic [HW-1:0]  crow_q;
	logic [LW-1:0]  cnt_q;

	logic [12:0]    cfg_ext;
	logic [DWW-1:0] width_cl;
	logic [DWH-1:0] height_cl;
	logic           in_frame, drop, fire, started, restart;
	logic [LW-1:0]  lag;
	logic [DWW:0]   cc_x, w_x;
	logic [DWH:0]   cr_x, h_x;

	assign cfg_ext = {2'b0, cfg_data};

	always_comb begin
		if (cfg_data == '0) begin
			width_cl  = DWW'(1);
			height_cl = DWH'(1);
		end else begin
			width_cl  = (cfg_ext > 13'(MAX_WIDTH)) ? DWW'(MAX_WIDTH) : DWW'(cfg_ext);
			height_cl = (cfg_ext > 13'(MAX_HEIGHT)) ? DWH'(MAX_HEIGHT) : DWH'(cfg_ext);
		end
	end

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign in_frame = row_q < RW'(height_q);
	assign drop     = in_flush && in_frame;
	assign push     = fire && !drop;

	assign lag     = LW'({width_q, 1'b0}) + LW'(2);
	assign started = cnt_q >= lag;

	assign cc_x = (DWW + 1)'(ccol_q);
	assign w_x  = (DWW + 1)'(width_q);
	assign cr_x = (DWH + 1)'(crow_q);
	assign h_x  = (DWH + 1)'(height_q);

	assign restart = started && (cc_x == w_x - 1'b1) && (cr_x == h_x - 1'b1);

	always_comb begin
		item.pix       = (in_frame && !in_flush) ? in_pix : 24'd0;
		item.col       = gpr_pkg::COL_BITS'(col_q);
		item.emit      = started && !crow_q[0] && !ccol_q[0];
		item.row_mask  = {cr_x + 2'd2 < h_x, cr_x + 1'b1 < h_x, 1'b1,
			cr_x >= 1, cr_x >= 2};
		item.col_mask  = {cc_x + 2'd2 < w_x, cc_x + 1'b1 < w_x, 1'b1,
			cc_x >= 1, cc_x >= 2};
		item.frame_end = item.emit
			&& (cr_x == ((h_x - 1'b1) & ~(DWH + 1)'(1)))
			&& (cc_x == ((w_x - 1'b1) & ~(DWW + 1)'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DWW'(W_RST);
			height_q <= DWH'(H_RST);
			col_q    <= '0;
			row_q    <= '0;
			ccol_q   <= '0;
			crow_q   <= '0;
			cnt_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == gpr_pkg::REG_FRAME_WIDTH) begin
				width_q <= width_cl;
			end
			if (cfg_index == gpr_pkg::REG_FRAME_HEIGHT) begin
				height_q <= height_cl;
			end
			if (cfg_index == gpr_pkg::REG_FRAME_WIDTH
				|| cfg_index == gpr_pkg::REG_FRAME_HEIGHT) begin
				col_q  <= '0;
				row_q  <= '0;
				ccol_q <= '0;
				crow_q <= '0;
				cnt_q  <= '0;
			end
		end else if (push) begin
			if (restart) begin
				col_q  <= '0;
				row_q  <= '0;
				ccol_q <= '0;
				crow_q <= '0;
				cnt_q  <= '0;
			end else begin
				if (!started) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (cc_x == w_x - 1'b1) begin
					ccol_q <= '0;
					crow_q <= crow_q + 1'b1;
				end else begin
					ccol_q <= ccol_q + 1'b1;
				end
				if ((DWW + 1)'(col_q) == w_x - 1'b1) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- sv/gpr_fifo.sv -----
// Short queue of classified items between front and back end.
// Depends on gpr_pkg.
module gpr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gpr_pkg::item_t wr_item,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output gpr_pkg::item_t rd_item
);

	localparam int PW = $clog2(gpr_pkg::FIFO_DEPTH);

	gpr_pkg::item_t  buf_q [gpr_pkg::FIFO_DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     count_q;

	assign full      = count_q == (PW + 1)'(gpr_pkg::FIFO_DEPTH);
	assign not_empty = count_q != '0;
	assign rd_item   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			count_q <= count_q + (PW + 1)'(push) - (PW + 1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW + 1)'(gpr_pkg::FIFO_DEPTH))
		else $error("queue count out of range");

endmodule

// ----- sv/gpr_back.sv -----
// Back end: line store update, 5x5 window, binomial sum tree, output register.
// Depends on gpr_pkg and gpr_ram.
module gpr_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  gpr_pkg::item_t q_item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [23:0]    out_data,   // red_out, green_out, blue_out
	output logic           out_last    // frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic            adv;
	logic            valid_s1, valid_s2, valid_s3;
	gpr_pkg::item_t  item_s1, item_s2;
	logic [95:0]     ram_rdata, rd_word, new_word, lw_data_q;
	logic [CW-1:0]   lw_addr_q;
	logic            lw_valid_q, we;
	logic [23:0]     win_q [5][5];   // [column][row], column 4 newest
	logic [11:0]     csum   [5][3];
	logic [11:0]     csum_s3 [5][3];
	logic [4:0]      cmask_s3;
	logic            emit_s3, fe_s3;
	logic [16:0]     total [3];
	logic [8:0]      rnd [3];
	logic [7:0]      sat [3];
	logic            out_valid_q, out_last_q;
	logic [23:0]     out_data_q;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && q_valid;
	assign we  = adv && valid_s1;

	gpr_ram #(.WIDTH(96), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (we),
		.waddr (item_s1.col[CW-1:0]),
		.wdata (new_word),
		.re    (pop),
		.raddr (q_item.col[CW-1:0]),
		.rdata (ram_rdata)
	);

	// read and write of back-to-back items to one column land in the same cycle
	assign rd_word  = (lw_valid_q && lw_addr_q == item_s1.col[CW-1:0]) ? lw_data_q : ram_rdata;
	assign new_word = {rd_word[71:0], item_s1.pix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			lw_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 5; c++) begin
				for (int r = 0; r < 5; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else if (adv) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3 && emit_s3;
			if (valid_s1) begin
				lw_valid_q <= 1'b1;
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 5; r++) begin
						win_q[c][r] <= win_q[c+1][r];
					end
				end
				win_q[4][0] <= rd_word[95:72];
				win_q[4][1] <= rd_word[71:48];
				win_q[4][2] <= rd_word[47:24];
				win_q[4][3] <= rd_word[23:0];
				win_q[4][4] <= item_s1.pix;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= q_item;
			item_s2  <= item_s1;
			csum_s3  <= csum;
			cmask_s3 <= item_s2.col_mask;
			emit_s3  <= item_s2.emit;
			fe_s3    <= item_s2.frame_end;
			out_data_q <= {sat[2], sat[1], sat[0]};
			out_last_q <= fe_s3;
			if (valid_s1) begin
				lw_addr_q <= item_s1.col[CW-1:0];
				lw_data_q <= new_word;
			end
		end
	end

	// vertical pass: channel 0 blue, 1 green, 2 red
	always_comb begin
		for (int c = 0; c < 5; c++) begin
			for (int ch = 0; ch < 3; ch++) begin
				csum[c][ch] = '0;
				for (int r = 0; r < 5; r++) begin
					if (item_s2.row_mask[r]) begin
						csum[c][ch] = csum[c][ch]
							+ 12'(gpr_pkg::TAP_WEIGHT[r]) * 12'(win_q[c][r][23-8*ch -: 8]);
					end
				end
			end
		end
	end

	// horizontal pass, single rounding, saturation
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			total[ch] = 17'd128;
			for (int c = 0; c < 5; c++) begin
				if (cmask_s3[c]) begin
					total[ch] = total[ch] + 17'(gpr_pkg::TAP_WEIGHT[c]) * 17'(csum_s3[c][ch]);
				end
			end
			rnd[ch] = total[ch][16:8];
			sat[ch] = rnd[ch][8] ? 8'hFF : rnd[ch][7:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule
